// ===== rtl/core/ugb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugb_pkg: shared types and constants
// Item layouts, mode codes and the command/status groups between the
// grid broadphase controller and datapath.
// ----------------------------------------------------------------------------
package ugb_pkg;

  localparam int COORD_W = 16;
  localparam int MAG_W   = 15;
  localparam int ID_W    = 6;
  localparam int MASK_W  = 64;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [ID_W-1:0]           actor_id;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
  } ugb_in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   querier_id;
    logic [MASK_W-1:0] candidate_mask;
  } ugb_out_item_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic start_ld;
    logic scan;
    logic out_load;
  } ugb_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              id_ok;
    logic              empty;
    logic              scan_last;
    logic              clr_last;
    logic              out_free;
  } ugb_sts_t;

endpackage

// ===== rtl/core/ugb_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugb_chan_if: valid/ready channel
// One item moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ugb_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ugb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugb_datapath: cell range, cell memory and result register
// Divides the box edges into cells, walks the covered cells through the
// cell mask memory and keeps the query result.
// ----------------------------------------------------------------------------
module ugb_datapath import ugb_pkg::*; #(
  parameter int GRID_COLS  = 16,
  parameter int GRID_ROWS  = 16,
  parameter int CELL_SIZE  = 64,
  parameter int MAX_ACTORS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ugb_in_item_t  in_data,
  input  ugb_cmd_t      cmd,
  output ugb_sts_t      sts,
  input  logic          out_ready,
  output logic          out_valid,
  output ugb_out_item_t out_data
);

  localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CX_W       = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int CY_W       = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int SHIFT      = MAG_W + $clog2(CELL_SIZE);
  localparam int RECIP_W    = MAG_W + 2;
  localparam longint RECIP  = ((longint'(1) << SHIFT) + CELL_SIZE - 1) / CELL_SIZE;
  localparam int PROD_W     = MAG_W + RECIP_W;
  localparam int ID_CMP_W   = ID_W + 1;

  localparam logic [MAG_W-1:0] X_LIM = MAG_W'(GRID_COLS - 1);
  localparam logic [MAG_W-1:0] Y_LIM = MAG_W'(GRID_ROWS - 1);
  localparam logic [MAG_W-1:0] LIM [4] = '{X_LIM, Y_LIM, X_LIM, Y_LIM};

  ugb_in_item_t              item_r;
  logic signed [COORD_W-1:0] coord [4];
  logic [PROD_W-1:0]         prod_r [4];
  logic                      neg_r [4];
  logic [MAG_W-1:0]          quo [4];
  logic [MAG_W-1:0]          cl [4];

  logic [CX_W-1:0]   x0_r, x1_r, x_r;
  logic [CY_W-1:0]   y0_r, y1_r, y_r;
  logic [ADDR_W-1:0] addr_r, row_step_r, wr_addr_r, clr_addr_r;
  logic              row_end;

  logic [MASK_W-1:0] mem [CELL_COUNT];
  logic [MASK_W-1:0] mem_q_r;
  logic              rd_vld_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [MASK_W-1:0] mem_wd;

  logic              is_insert, is_query;
  logic [MASK_W-1:0] id_bit, above;
  logic [MASK_W-1:0] acc_r;
  logic              out_valid_r;
  ugb_out_item_t     out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  assign coord[0] = item_r.box_min_x;
  assign coord[1] = item_r.box_min_y;
  assign coord[2] = item_r.box_max_x;
  assign coord[3] = item_r.box_max_y;

  // negative edges truncate toward zero and always clamp to cell 0
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      neg_r[i]  <= coord[i][COORD_W-1];
      prod_r[i] <= PROD_W'(coord[i][MAG_W-1:0]) * PROD_W'(RECIP);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      quo[i] = MAG_W'(prod_r[i] >> SHIFT);
      cl[i]  = neg_r[i] ? '0 : ((quo[i] > LIM[i]) ? LIM[i] : quo[i]);
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= CX_W'(cl[0]);
    y0_r <= CY_W'(cl[1]);
    x1_r <= CX_W'(cl[2]);
    y1_r <= CY_W'(cl[3]);
  end

  assign row_end = (x_r == x1_r);

  always_ff @(posedge clk) begin
    if (cmd.start_ld) begin
      x_r        <= x0_r;
      y_r        <= y0_r;
      addr_r     <= ADDR_W'(ADDR_W'(y0_r) * ADDR_W'(GRID_COLS)) + ADDR_W'(x0_r);
      row_step_r <= ADDR_W'(GRID_COLS) - ADDR_W'(x1_r) + ADDR_W'(x0_r);
    end else if (cmd.scan) begin
      if (row_end) begin
        x_r    <= x0_r;
        y_r    <= y_r + CY_W'(1);
        addr_r <= addr_r + row_step_r;
      end else begin
        x_r    <= x_r + CX_W'(1);
        addr_r <= addr_r + ADDR_W'(1);
      end
    end
  end

  // read one cell a cycle, merge or write back in the cycle after the read
  assign is_insert = (item_r.mode == MODE_INSERT);
  assign is_query  = (item_r.mode == MODE_QUERY);
  assign id_bit    = MASK_W'(1) << item_r.actor_id;
  assign above     = ({MASK_W{1'b1}} << item_r.actor_id) << 1;

  assign mem_we = cmd.clr_step | (rd_vld_r & is_insert);
  assign mem_wa = cmd.clr_step ? clr_addr_r : wr_addr_r;
  assign mem_wd = cmd.clr_step ? '0 : (mem_q_r | id_bit);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.scan) begin
      mem_q_r <= mem[addr_r];
    end
    wr_addr_r <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      rd_vld_r   <= cmd.scan;
      clr_addr_r <= cmd.clr_step ? clr_addr_r + ADDR_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= '0;
    end else if (rd_vld_r && is_query) begin
      acc_r <= acc_r | mem_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.querier_id     <= item_r.actor_id;
      out_data_r.candidate_mask <= acc_r & above;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.mode      = item_r.mode;
  assign sts.id_ok     = ({1'b0, item_r.actor_id} < ID_CMP_W'(MAX_ACTORS));
  assign sts.empty     = (x1_r < x0_r) || (y1_r < y0_r);
  assign sts.scan_last = row_end && (y_r == y1_r);
  assign sts.clr_last  = (clr_addr_r == ADDR_W'(CELL_COUNT - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

// ===== rtl/core/ugb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugb_ctrl: broadphase sequencer
// Steps each item through range setup, the cell walk, the result hand-off
// and the clearing sweep.
// ----------------------------------------------------------------------------
module ugb_ctrl import ugb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ugb_sts_t sts,
  output ugb_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CALC   = 3'd1;
  localparam logic [2:0] S_RANGE  = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;
  localparam logic [2:0] S_CLEAR  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       skip;

  assign in_ready = (state_r == S_IDLE);
  assign skip     = sts.empty || ((sts.mode == MODE_INSERT) && !sts.id_ok);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.load     = in_ready && in_valid;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CALC;
      end
      S_CALC: begin
        case (sts.mode)
          MODE_CLEAR:  state_nxt = S_CLEAR;
          MODE_INSERT: state_nxt = S_RANGE;
          MODE_QUERY:  state_nxt = S_RANGE;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_RANGE: begin
        state_nxt = S_START;
      end
      S_START: begin
        cmd.start_ld = 1'b1;
        if (skip) begin
          state_nxt = (sts.mode == MODE_QUERY) ? S_RESULT : S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = (sts.mode == MODE_QUERY) ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/uniform_grid_broadphase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_broadphase: uniform grid collision broadphase
// Keeps one actor mask per grid cell; inserts set an actor's bit over its
// box, queries OR the covered cells and keep actors above the querier.
//
//   channel   dir  payload                                    notes
//   in_chan   in   mode, actor_id, box_min_x/y, box_max_x/y   clear/insert/query
//   out_chan  out  querier_id, candidate_mask                 one per query
//
// Insert and query go through CALC, RANGE and START, then walk the covered
// cells; with no covered cell (or an ignored insert) the walk is skipped.
// An unused mode returns to idle from CALC. The single read port of the
// cell memory walks one cell per cycle. Clear: one cell cleared per cycle.
// After reset a sweep of all GRID_COLS * GRID_ROWS cells runs before
// in_chan is ready. A query waits in place while an earlier result is not
// taken; new items are accepted while a result sits in the output register.
// ----------------------------------------------------------------------------
module uniform_grid_broadphase import ugb_pkg::*; #(
  parameter int GRID_COLS  = 16,
  parameter int GRID_ROWS  = 16,
  parameter int CELL_SIZE  = 64,
  parameter int MAX_ACTORS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ugb_chan_if.sink   in_chan,
  ugb_chan_if.source out_chan
);

  ugb_cmd_t cmd;
  ugb_sts_t sts;

  ugb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ugb_datapath #(
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .CELL_SIZE  (CELL_SIZE),
    .MAX_ACTORS (MAX_ACTORS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_chan.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_data  (out_chan.data)
  );

`ifndef SYNTHESIS
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending result");

  a_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> (!cmd.scan && !cmd.clr_step))
    else $error("input ready while cell work in progress");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clr_step && sts.clr_last) |=> !cmd.clr_step)
    else $error("clearing sweep ran past the last cell");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && sts.scan_last) |=> !cmd.scan)
    else $error("cell walk ran past the last covered cell");
`endif

endmodule

// ===== test/tb_uniform_grid_broadphase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uniform_grid_broadphase: self-checking bench for the grid broadphase
// Walks a short table of directed items (extremes, clamping, inverted
// boxes, top querier, clear, unused mode), then random insert/query
// traffic with occasional clears. A local copy of the cell masks predicts
// every query answer; answers are checked in order, field by field.
// Both channels idle at random, with stretches of no idling.
// ----------------------------------------------------------------------------
module tb_uniform_grid_broadphase;
  import ugb_pkg::*;

  localparam int GRID_COLS  = 16;
  localparam int GRID_ROWS  = 16;
  localparam int CELL_SIZE  = 64;
  localparam int MAX_ACTORS = 64;
  localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int RAND_ITEMS = 1000;
  localparam int CYCLE_LIMIT = 1200000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    ugb_in_item_t item;
    bit           typed;
    logic [63:0]  mask;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ugb_chan_if #(.T(ugb_in_item_t))  in_chan ();
  ugb_chan_if #(.T(ugb_out_item_t)) out_chan ();

  uniform_grid_broadphase #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .CELL_SIZE (CELL_SIZE),
    .MAX_ACTORS(MAX_ACTORS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  logic [MASK_W-1:0] cell_occupancy [CELL_COUNT];
  ugb_out_item_t     pending_answers [$];
  stim_row_t         dir_rows [$];
  ugb_out_item_t     predicted;
  ugb_out_item_t     answer;
  bit                row_typed;
  logic [63:0]       row_mask;
  bit                no_idle;
  int                mismatch_count;
  int                rx_hold;
  int                cycle_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int grid_cell(logic signed [COORD_W-1:0] coord, int limit);
    int c;
    c = int'(coord) / CELL_SIZE;
    if (c < 0) c = 0;
    if (c > limit - 1) c = limit - 1;
    return c;
  endfunction

  // Applies one item to the local grid; returns 1 when a query answer is due.
  function automatic bit broadphase_apply(ugb_in_item_t it, output ugb_out_item_t res);
    int x0, y0, x1, y1;
    logic [MASK_W-1:0] acc;
    logic [MASK_W-1:0] above;
    res = '0;
    x0 = grid_cell(it.box_min_x, GRID_COLS);
    y0 = grid_cell(it.box_min_y, GRID_ROWS);
    x1 = grid_cell(it.box_max_x, GRID_COLS);
    y1 = grid_cell(it.box_max_y, GRID_ROWS);
    acc = '0;
    case (it.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) cell_occupancy[i] = '0;
        return 1'b0;
      end
      MODE_INSERT: begin
        if (int'(it.actor_id) < MAX_ACTORS) begin
          for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++)
              cell_occupancy[y * GRID_COLS + x][it.actor_id] = 1'b1;
        end
        return 1'b0;
      end
      MODE_QUERY: begin
        above = (it.actor_id == 6'd63) ? '0 : ({MASK_W{1'b1}} << (it.actor_id + 1));
        for (int y = y0; y <= y1; y++)
          for (int x = x0; x <= x1; x++)
            acc |= cell_occupancy[y * GRID_COLS + x];
        res.querier_id     = it.actor_id;
        res.candidate_mask = acc & above;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic ugb_in_item_t mk(logic [MODE_W-1:0] m, int id, int x0, int y0,
                                      int x1, int y1);
    ugb_in_item_t it;
    it.mode      = m;
    it.actor_id  = id[ID_W-1:0];
    it.box_min_x = x0[COORD_W-1:0];
    it.box_min_y = y0[COORD_W-1:0];
    it.box_max_x = x1[COORD_W-1:0];
    it.box_max_y = y1[COORD_W-1:0];
    return it;
  endfunction

  function automatic void add_row(ugb_in_item_t it, bit typed, logic [63:0] tmask);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.mask  = tmask;
    dir_rows  = {dir_rows, row};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom());
  endfunction

  task automatic send_item(ugb_in_item_t it, bit typed, logic [63:0] tmask);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    row_typed     <= typed;
    row_mask      <= tmask;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      if (broadphase_apply(in_chan.data, predicted)) begin
        if (row_typed) predicted.candidate_mask = row_mask;
        pending_answers = {pending_answers, predicted};
      end
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      answer = out_chan.data;
      if (pending_answers.size() == 0) begin
        $display("ERROR t=%0t unexpected answer querier_id %0d mask %h", $time,
                 answer.querier_id, answer.candidate_mask);
        mismatch_count++;
      end else begin
        predicted = pending_answers.pop_front();
        if (answer.querier_id !== predicted.querier_id) begin
          $display("ERROR t=%0t querier_id exp %0d got %0d", $time,
                   predicted.querier_id, answer.querier_id);
          mismatch_count++;
        end
        if (answer.candidate_mask !== predicted.candidate_mask) begin
          $display("ERROR t=%0t candidate_mask exp %h got %h", $time,
                   predicted.candidate_mask, answer.candidate_mask);
          mismatch_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (no_idle) begin
      out_chan.ready <= 1'b1;
    end else if (rx_hold > 0) begin
      out_chan.ready <= 1'b0;
      rx_hold--;
    end else begin
      out_chan.ready <= 1'b1;
      rx_hold = pick_gap();
    end
  end

  initial begin
    ugb_in_item_t it;
    int r;
    int q;
    int x0, y0;

    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    row_typed      = 1'b0;
    row_mask       = '0;
    no_idle        = 1'b0;
    mismatch_count = 0;
    rx_hold        = 0;
    cycle_count    = 0;
    for (int i = 0; i < CELL_COUNT; i++) cell_occupancy[i] = '0;

    // empty grid after reset
    add_row(mk(MODE_QUERY, 0, -32768, -32768, 32767, 32767), 1'b1, 64'd0);
    add_row(mk(MODE_INSERT, 5, 0, 0, 63, 63), 1'b0, 64'd0);
    add_row(mk(MODE_INSERT, 63, -32768, -32768, 32767, 32767), 1'b0, 64'd0);
    add_row(mk(MODE_INSERT, 0, 100, 100, 200, 200), 1'b0, 64'd0);
    add_row(mk(MODE_QUERY, 0, 0, 0, 0, 0), 1'b0, 64'd0);
    // top querier
    add_row(mk(MODE_QUERY, 63, -32768, -32768, 32767, 32767), 1'b1, 64'd0);
    // negative quotients clamp to cell 0
    add_row(mk(MODE_QUERY, 4, -32768, -32768, -1, -1), 1'b0, 64'd0);
    add_row(mk(MODE_INSERT, 10, 200, 0, 100, 0), 1'b0, 64'd0);
    // inverted boxes answer zero
    add_row(mk(MODE_QUERY, 1, 500, 500, 0, 0), 1'b1, 64'd0);
    add_row(mk(MODE_QUERY, 1, 0, 700, 0, 100), 1'b1, 64'd0);
    add_row(mk(MODE_QUERY, 9, 100, 0, 300, 0), 1'b0, 64'd0);
    add_row(mk(MODE_UNUSED, 63, -1, -1, -1, -1), 1'b0, 64'd0);
    add_row(mk(MODE_INSERT, 62, 1023, 1023, 1024, 1024), 1'b0, 64'd0);
    add_row(mk(MODE_QUERY, 61, 32767, 32767, 32767, 32767), 1'b0, 64'd0);
    add_row(mk(MODE_QUERY, 62, 960, 960, 32767, 32767), 1'b0, 64'd0);
    add_row(mk(MODE_INSERT, 20, -63, -63, -63, -63), 1'b0, 64'd0);
    add_row(mk(MODE_QUERY, 19, 63, 63, 63, 63), 1'b0, 64'd0);
    add_row(mk(MODE_CLEAR, 63, 32767, 32767, -32768, -32768), 1'b0, 64'd0);
    add_row(mk(MODE_QUERY, 0, -32768, -32768, 32767, 32767), 1'b1, 64'd0);
    add_row(mk(MODE_INSERT, 33, -100, 960, 70, 32767), 1'b0, 64'd0);
    add_row(mk(MODE_QUERY, 32, 0, 1000, 0, 1000), 1'b0, 64'd0);
    add_row(mk(MODE_QUERY, 33, 0, 1000, 0, 1000), 1'b0, 64'd0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].mask);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      no_idle = (n >= 300 && n < 380) || (n >= 700 && n < 760);
      if (n % 200 == 100) begin
        @(negedge clk);
        in_chan.valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      q = $urandom_range(0, 99);
      it.actor_id = ID_W'($urandom_range(0, 63));
      if (q < 85) begin
        x0 = int'($urandom_range(0, 1300)) - 150;
        y0 = int'($urandom_range(0, 1300)) - 150;
        it.box_min_x = x0[COORD_W-1:0];
        it.box_min_y = y0[COORD_W-1:0];
        x0 = x0 + int'($urandom_range(0, 160));
        y0 = y0 + int'($urandom_range(0, 160));
        it.box_max_x = x0[COORD_W-1:0];
        it.box_max_y = y0[COORD_W-1:0];
      end else if (q < 95) begin
        it.box_min_x = rand_coord();
        it.box_min_y = rand_coord();
        it.box_max_x = rand_coord();
        it.box_max_y = rand_coord();
      end else begin
        x0 = int'($urandom_range(0, 5000)) - 2000;
        y0 = int'($urandom_range(0, 5000)) - 2000;
        it.box_min_x = x0[COORD_W-1:0];
        it.box_min_y = y0[COORD_W-1:0];
        x0 = int'($urandom_range(0, 5000)) - 2000;
        y0 = int'($urandom_range(0, 5000)) - 2000;
        it.box_max_x = x0[COORD_W-1:0];
        it.box_max_y = y0[COORD_W-1:0];
      end
      if (r < 2) begin
        it.mode = MODE_CLEAR;
      end else if (r < 4) begin
        it.mode      = MODE_UNUSED;
        it.box_min_x = rand_coord();
        it.box_max_y = rand_coord();
      end else if (r < 50) begin
        it.mode = MODE_INSERT;
      end else begin
        it.mode = MODE_QUERY;
      end
      send_item(it, 1'b0, 64'd0);
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (CELL_COUNT + 50) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ugb_pkg.sv
rtl/core/ugb_chan_if.sv
rtl/core/ugb_datapath.sv
rtl/core/ugb_ctrl.sv
rtl/core/uniform_grid_broadphase.sv
test/tb_uniform_grid_broadphase.sv
